[design/acss_pkg.sv]
// Shared types and constants for the ADC channel scan sequencer.
// No dependencies; compile first.
`timescale 1ns / 1ps

package acss_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int RD_CHAN_W  = 4;
   localparam int CHAN_OUT_W = 3;
   localparam int REF_W      = 2;
   localparam int MASK_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic KIND_CONV = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_MASK    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REFERENCE_SEL   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_RESOLUTION = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic accept_conv;
      logic accept_read;
      logic search_step;
      logic finish_search;
   } cmd_type;

   typedef struct packed {
      logic usable_any;
      logic hit;
   } status_type;

endpackage

[design/acss_req_if.sv]
// Request channel interface: conversion-done and read beats.
// Depends on acss_pkg.
`timescale 1ns / 1ps

interface acss_req_if;
   import acss_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [SAMPLE_W-1:0]  sample;
   logic [RD_CHAN_W-1:0] read_channel;

   modport source (output valid, kind, sample, read_channel, input ready);
   modport sink   (input valid, kind, sample, read_channel, output ready);
endinterface

[design/acss_rsp_if.sv]
// Response channel interface: one result beat per request beat.
// Depends on acss_pkg.
`timescale 1ns / 1ps

interface acss_rsp_if;
   import acss_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CHAN_OUT_W-1:0] next_channel;
   logic                  start_conversion;
   logic [SAMPLE_W-1:0]   read_data;
   logic [REF_W-1:0]      reference_bits;
   logic                  left_adjust;

   modport source (output valid, next_channel, start_conversion, read_data,
                   reference_bits, left_adjust, input ready);
   modport sink   (input valid, next_channel, start_conversion, read_data,
                   reference_bits, left_adjust, output ready);
endinterface

[design/acss_datapath.sv]
// Datapath: config registers, result store, scan pointer and response registers.
// Depends on acss_pkg; driven by acss_ctrl commands.
`timescale 1ns / 1ps

module acss_datapath #(
   parameter int NUM_CHANNELS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [acss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [acss_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [acss_pkg::SAMPLE_W-1:0]     sample,
   input  logic [acss_pkg::RD_CHAN_W-1:0]    read_channel,
   input  acss_pkg::cmd_type                 cmd,
   output acss_pkg::status_type              status,
   output logic [acss_pkg::CHAN_OUT_W-1:0]   next_channel,
   output logic                              start_conversion,
   output logic [acss_pkg::SAMPLE_W-1:0]     read_data,
   output logic [acss_pkg::REF_W-1:0]        reference_bits,
   output logic                              left_adjust
);
   import acss_pkg::*;

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [IDX_W-1:0] LAST_CH = IDX_W'(NUM_CHANNELS - 1);

   logic [MASK_W-1:0]   mask_ff, mask_in;
   logic [REF_W-1:0]    ref_ff, ref_in;
   logic                full_res_ff, full_res_in;
   logic                started_ff, started_in;
   logic [IDX_W-1:0]    cur_ff, cur_in;
   logic [IDX_W-1:0]    ptr_ff, ptr_in;
   logic [SAMPLE_W-1:0] store_ff [NUM_CHANNELS];
   logic                start_ff, start_in;
   logic [SAMPLE_W-1:0] data_ff, data_in;

   logic [NUM_CHANNELS-1:0] usable;
   logic                    store_wr;
   logic                    rd_in_range;

   function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] c);
      wrap_next = (c == LAST_CH) ? '0 : c + 1'b1;
   endfunction

   assign usable            = mask_ff[NUM_CHANNELS-1:0];
   assign status.usable_any = |usable;
   assign status.hit        = usable[ptr_ff];
   assign store_wr          = cmd.accept_conv && started_ff;
   assign rd_in_range       = read_channel < RD_CHAN_W'(NUM_CHANNELS);

   always_comb begin
      mask_in     = mask_ff;
      ref_in      = ref_ff;
      full_res_in = full_res_ff;
      started_in  = started_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_CHANNEL_MASK: begin
               mask_in = csr_wdata[MASK_W-1:0];
               if (mask_ff == '0 && csr_wdata[MASK_W-1:0] != '0)
                  started_in = 1'b0;
            end
            REG_REFERENCE_SEL:   ref_in      = csr_wdata[REF_W-1:0];
            REG_FULL_RESOLUTION: full_res_in = csr_wdata[0];
            default: ;
         endcase
      end
      if (cmd.accept_conv)
         started_in = 1'b1;
   end

   always_comb begin
      cur_in   = cur_ff;
      ptr_in   = ptr_ff;
      start_in = start_ff;
      data_in  = data_ff;
      if (cmd.accept_conv) begin
         start_in = 1'b0;
         data_in  = '0;
         if (started_ff) begin
            ptr_in = wrap_next(cur_ff);
         end else begin
            ptr_in = '0;
            cur_in = '0;
         end
      end
      if (cmd.accept_read) begin
         start_in = 1'b0;
         data_in  = rd_in_range ? store_ff[read_channel[IDX_W-1:0]] : '0;
      end
      if (cmd.search_step)
         ptr_in = wrap_next(ptr_ff);
      if (cmd.finish_search && status.usable_any) begin
         cur_in   = ptr_ff;
         start_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff     <= '0;
         ref_ff      <= '0;
         full_res_ff <= 1'b1;
         started_ff  <= 1'b0;
         cur_ff      <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++)
            store_ff[i] <= '0;
      end else begin
         mask_ff     <= mask_in;
         ref_ff      <= ref_in;
         full_res_ff <= full_res_in;
         started_ff  <= started_in;
         cur_ff      <= cur_in;
         if (store_wr)
            store_ff[cur_ff] <= sample;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff   <= ptr_in;
      start_ff <= start_in;
      data_ff  <= data_in;
   end

   assign next_channel     = CHAN_OUT_W'(cur_ff);
   assign start_conversion = start_ff;
   assign read_data        = data_ff;
   assign reference_bits   = ref_ff;
   assign left_adjust      = ~full_res_ff;

   a_finish_hits: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish_search && status.usable_any) |-> status.hit)
      else $error("search finished on a disabled channel");

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept_conv, cmd.accept_read, cmd.search_step, cmd.finish_search}))
      else $error("more than one datapath command");

   a_conv_sets_started: assert property (@(posedge clock) disable iff (reset)
      cmd.accept_conv |=> started_ff)
      else $error("scan not marked started after conversion beat");

endmodule

[design/acss_ctrl.sv]
// Controller FSM: accepts a request beat, steps the channel search, holds the response.
// Depends on acss_pkg; drives acss_datapath.
`timescale 1ns / 1ps

module acss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_kind,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  acss_pkg::status_type status,
   output acss_pkg::cmd_type    cmd
);
   import acss_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid)
               state_in = (req_kind == KIND_READ) ? ST_RESP : ST_SEARCH;
         end
         ST_SEARCH: begin
            if (!status.usable_any || status.hit)
               state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept_conv = (req_kind == KIND_CONV);
               cmd.accept_read = (req_kind == KIND_READ);
            end
         end
         ST_SEARCH: begin
            if (!status.usable_any || status.hit)
               cmd.finish_search = 1'b1;
            else
               cmd.search_step = 1'b1;
         end
         ST_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second beat accepted while one is in flight");

   a_read_to_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.accept_read |=> rsp_valid)
      else $error("read beat not answered next cycle");

   a_finish_to_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.finish_search |=> (rsp_valid && !req_ready))
      else $error("search end not followed by response");

endmodule

[design/adc_channel_scan_sequencer_top.sv]
// Top level of the ADC channel scan sequencer: controller plus datapath.
// Depends on acss_pkg, acss_req_if, acss_rsp_if, acss_ctrl, acss_datapath.
//
//   channel   dir  handshake        payload
//   req_chan  in   valid/ready      kind, sample, read_channel
//   rsp_chan  out  valid/ready      next_channel, start_conversion, read_data,
//                                   reference_bits, left_adjust
//   csr_*     in   csr_wr_en only   csr_index, csr_wdata
//
// A read beat's response is valid the cycle after it is taken; a conversion
// beat first goes through the channel search, which tests one mask bit at a
// time. One beat is in flight at a time; req_chan is ready again the cycle
// after the response beat is taken, so a new beat waits for the last reply.
// Synchronous reset clears the result store and the scan position and sets
// the config registers to their defaults. A stalled response holds.
`timescale 1ns / 1ps

module adc_channel_scan_sequencer_top #(
   parameter int NUM_CHANNELS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   acss_req_if.sink                         req_chan,
   acss_rsp_if.source                       rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [acss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [acss_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import acss_pkg::*;

   cmd_type    cmd;
   status_type status;

   acss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   acss_datapath #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .sample           (req_chan.sample),
      .read_channel     (req_chan.read_channel),
      .cmd              (cmd),
      .status           (status),
      .next_channel     (rsp_chan.next_channel),
      .start_conversion (rsp_chan.start_conversion),
      .read_data        (rsp_chan.read_data),
      .reference_bits   (rsp_chan.reference_bits),
      .left_adjust      (rsp_chan.left_adjust)
   );

endmodule
